[hw/rtl/gdsu_pkg.sv]
// Shared types, constants and calendar functions for the Gregorian date step unit.
package gdsu_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int CNT_W   = 16;
	localparam int DC_W    = 22;
	localparam int WD_W    = 3;
	localparam int MODE_W  = 3;

	localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

	typedef enum logic [MODE_W-1:0] {
		MODE_NEXT    = 3'd0,
		MODE_PREV    = 3'd1,
		MODE_ADD     = 3'd2,
		MODE_SUB     = 3'd3,
		MODE_BETWEEN = 3'd4,
		MODE_WEEKDAY = 3'd5
	} mode_t;

	// Field order makes the packed value compare in calendar order.
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		date_t cur;
		logic  fwd;
	} step_req_t;

	typedef struct packed {
		date_t nxt;
		logic  at_limit;
	} step_rsp_t;

	localparam date_t FIRST_DATE = '{year: '0, month: 4'd1, day: 5'd1};
	localparam date_t LAST_DATE  = '{year: MAX_YEAR, month: 4'd12, day: 5'd31};
	// Monday, weekday zero
	localparam date_t REF_DATE   = '{year: 14'd2020, month: 4'd12, day: 5'd7};

	// y % 100 through a reciprocal multiply; y % 400 == 0 iff also (y / 100) % 4 == 0.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [26:0]       prod;
		logic [7:0]        q;
		logic [YEAR_W-1:0] r100;
		prod = 27'(y) * 27'(13'd5243);
		q    = prod[26:19];
		r100 = y - (YEAR_W'(q) * YEAR_W'(100));
		return (y[1:0] == 2'd0) && ((r100 != '0) || (q[1:0] == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic [YEAR_W-1:0] y);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2: begin
				len = is_leap(y) ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				len = 5'd30;
			end
			default: begin
				len = 5'd31;
			end
		endcase
		return len;
	endfunction

	function automatic logic date_ok(input date_t dt);
		return (dt.year <= MAX_YEAR) && (dt.month >= 4'd1) && (dt.month <= 4'd12)
			&& (dt.day >= 5'd1) && (dt.day <= month_len(dt.month, dt.year));
	endfunction

endpackage

[hw/rtl/gdsu_step.sv]
// Shared day stepper: moves one date a single day forward or back.
module gdsu_step (
	input  gdsu_pkg::step_req_t req,
	output gdsu_pkg::step_rsp_t rsp
);

	logic [gdsu_pkg::DAY_W-1:0] len_cur;
	logic [gdsu_pkg::DAY_W-1:0] len_prev;

	always_comb begin
		len_cur  = gdsu_pkg::month_len(req.cur.month, req.cur.year);
		len_prev = gdsu_pkg::month_len(req.cur.month - 4'd1, req.cur.year);
		rsp.nxt  = req.cur;
		if (req.fwd) begin
			rsp.at_limit = (req.cur == gdsu_pkg::LAST_DATE);
			if (req.cur.day < len_cur) begin
				rsp.nxt.day = req.cur.day + 5'd1;
			end else if (req.cur.month < 4'd12) begin
				rsp.nxt.month = req.cur.month + 4'd1;
				rsp.nxt.day   = 5'd1;
			end else begin
				rsp.nxt.year  = req.cur.year + 14'd1;
				rsp.nxt.month = 4'd1;
				rsp.nxt.day   = 5'd1;
			end
		end else begin
			rsp.at_limit = (req.cur == gdsu_pkg::FIRST_DATE);
			if (req.cur.day > 5'd1) begin
				rsp.nxt.day = req.cur.day - 5'd1;
			end else if (req.cur.month > 4'd1) begin
				rsp.nxt.month = req.cur.month - 4'd1;
				rsp.nxt.day   = len_prev;
			end else begin
				rsp.nxt.year  = req.cur.year - 14'd1;
				rsp.nxt.month = 4'd12;
				rsp.nxt.day   = 5'd31;
			end
		end
	end

endmodule

[hw/rtl/gdsu_ctrl.sv]
// Sequencer: latches an item, validates it, drives the stepper and forms the result.
module gdsu_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gdsu_pkg::MODE_W-1:0]   mode,
	input  logic [gdsu_pkg::DAY_W-1:0]    day,
	input  logic [gdsu_pkg::MONTH_W-1:0]  month,
	input  logic [gdsu_pkg::YEAR_W-1:0]   year,
	input  logic [gdsu_pkg::CNT_W-1:0]    count,
	input  logic [gdsu_pkg::DAY_W-1:0]    other_day,
	input  logic [gdsu_pkg::MONTH_W-1:0]  other_month,
	input  logic [gdsu_pkg::YEAR_W-1:0]   other_year,
	output logic                          busy,
	output logic                          done,
	output logic [gdsu_pkg::DAY_W-1:0]    result_day,
	output logic [gdsu_pkg::MONTH_W-1:0]  result_month,
	output logic [gdsu_pkg::YEAR_W-1:0]   result_year,
	output logic [gdsu_pkg::DC_W-1:0]     day_count,
	output logic [gdsu_pkg::WD_W-1:0]     weekday,
	output logic                          error,
	output gdsu_pkg::step_req_t           step_req,
	input  gdsu_pkg::step_rsp_t           step_rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN
	} state_t;

	state_t                         state_q;
	logic                           done_q;
	logic                           err_q;
	gdsu_pkg::date_t                res_q;
	logic [gdsu_pkg::DC_W-1:0]      dc_q;
	logic [gdsu_pkg::WD_W-1:0]      wd_q;

	logic [gdsu_pkg::MODE_W-1:0]    mode_q;
	gdsu_pkg::date_t                pri_q;
	gdsu_pkg::date_t                oth_q;
	logic [gdsu_pkg::CNT_W-1:0]     cnt_q;
	gdsu_pkg::date_t                cur_q;
	gdsu_pkg::date_t                tgt_q;
	logic                           fwd_q;
	logic [gdsu_pkg::CNT_W-1:0]     rem_q;
	logic [gdsu_pkg::DC_W-1:0]      k_q;
	logic [gdsu_pkg::WD_W-1:0]      k7_q;
	logic                           neg_q;

	logic                           accept;
	logic                           chk_bad;
	logic                           cnt_mode;
	logic                           pri_ge_oth;
	logic                           pri_ge_ref;
	logic                           run_end;
	logic                           run_err;
	logic [gdsu_pkg::WD_W-1:0]      wd_val;

	always_comb begin
		accept     = start && (state_q == ST_IDLE);
		chk_bad    = (mode_q > gdsu_pkg::MODE_WEEKDAY) || !gdsu_pkg::date_ok(pri_q)
			|| ((mode_q == gdsu_pkg::MODE_BETWEEN) && !gdsu_pkg::date_ok(oth_q));
		cnt_mode   = (mode_q <= gdsu_pkg::MODE_SUB);
		pri_ge_oth = (pri_q >= oth_q);
		pri_ge_ref = (pri_q >= gdsu_pkg::REF_DATE);
		// Count modes stop when the budget is spent or the calendar edge is hit.
		run_end    = cnt_mode ? ((rem_q == '0) || step_rsp.at_limit) : (cur_q == tgt_q);
		run_err    = cnt_mode && (rem_q != '0);
		if (neg_q && (k7_q != '0)) begin
			wd_val = 3'd7 - k7_q;
		end else begin
			wd_val = k7_q;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign error         = err_q;
	assign result_day    = res_q.day;
	assign result_month  = res_q.month;
	assign result_year   = res_q.year;
	assign day_count     = dc_q;
	assign weekday       = wd_q;
	assign step_req.cur  = cur_q;
	assign step_req.fwd  = fwd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			err_q   <= 1'b0;
			res_q   <= '0;
			dc_q    <= '0;
			wd_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (chk_bad) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						err_q   <= 1'b1;
						res_q   <= '0;
						dc_q    <= '0;
						wd_q    <= '0;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (run_end) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
						err_q   <= run_err;
						res_q   <= (cnt_mode && !run_err) ? cur_q : '0;
						dc_q    <= (mode_q == gdsu_pkg::MODE_BETWEEN) ? k_q : '0;
						wd_q    <= (mode_q == gdsu_pkg::MODE_WEEKDAY) ? wd_val : '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			pri_q  <= '{year: year, month: month, day: day};
			oth_q  <= '{year: other_year, month: other_month, day: other_day};
			cnt_q  <= count;
		end
		if (state_q == ST_CHECK) begin
			cur_q <= pri_q;
			tgt_q <= pri_q;
			rem_q <= '0;
			fwd_q <= 1'b1;
			k_q   <= '0;
			k7_q  <= '0;
			neg_q <= !pri_ge_ref;
			case (mode_q)
				gdsu_pkg::MODE_NEXT: begin
					rem_q <= 16'd1;
				end
				gdsu_pkg::MODE_PREV: begin
					rem_q <= 16'd1;
					fwd_q <= 1'b0;
				end
				gdsu_pkg::MODE_ADD: begin
					rem_q <= cnt_q;
				end
				gdsu_pkg::MODE_SUB: begin
					rem_q <= cnt_q;
					fwd_q <= 1'b0;
				end
				gdsu_pkg::MODE_BETWEEN: begin
					cur_q <= pri_ge_oth ? oth_q : pri_q;
					tgt_q <= pri_ge_oth ? pri_q : oth_q;
				end
				default: begin
					// walk from the earlier of date and reference to the later
					cur_q <= pri_ge_ref ? gdsu_pkg::REF_DATE : pri_q;
					tgt_q <= pri_ge_ref ? pri_q : gdsu_pkg::REF_DATE;
				end
			endcase
		end else if ((state_q == ST_RUN) && !run_end) begin
			cur_q <= step_rsp.nxt;
			rem_q <= rem_q - 16'd1;
			k_q   <= k_q + 22'd1;
			k7_q  <= (k7_q == 3'd6) ? 3'd0 : (k7_q + 3'd1);
		end
	end

endmodule

[hw/rtl/gregorian_date_step_unit.sv]
// Top level of the Gregorian date step unit: sequencer plus shared day stepper.
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------------
//  item in   | start, accepted !busy  | mode, day, month, year, count, other_*
//  result    | done, one-cycle strobe | result_day/month/year, day_count, weekday, error
//
// An accepted item is first validated, then the shared stepper walks one calendar
// day per cycle, and the result is formed once the walk ends.
// Invalid dates and unused modes finish after the validation cycle.
// The result is shown for exactly one cycle with done; the receiver cannot stall.
// Reset (arst_n low) drops any item at work and returns to idle.
module gregorian_date_step_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gdsu_pkg::MODE_W-1:0]   mode,
	input  logic [gdsu_pkg::DAY_W-1:0]    day,
	input  logic [gdsu_pkg::MONTH_W-1:0]  month,
	input  logic [gdsu_pkg::YEAR_W-1:0]   year,
	input  logic [gdsu_pkg::CNT_W-1:0]    count,
	input  logic [gdsu_pkg::DAY_W-1:0]    other_day,
	input  logic [gdsu_pkg::MONTH_W-1:0]  other_month,
	input  logic [gdsu_pkg::YEAR_W-1:0]   other_year,
	output logic                          done,
	output logic [gdsu_pkg::DAY_W-1:0]    result_day,
	output logic [gdsu_pkg::MONTH_W-1:0]  result_month,
	output logic [gdsu_pkg::YEAR_W-1:0]   result_year,
	output logic [gdsu_pkg::DC_W-1:0]     day_count,
	output logic [gdsu_pkg::WD_W-1:0]     weekday,
	output logic                          error
);

	// Request from the sequencer (current date, direction) and the stepped date back.
	gdsu_pkg::step_req_t step_req;
	gdsu_pkg::step_rsp_t step_rsp;

	// Sequencer: holds the item, counts steps and builds the result.
	gdsu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.mode         (mode),
		.day          (day),
		.month        (month),
		.year         (year),
		.count        (count),
		.other_day    (other_day),
		.other_month  (other_month),
		.other_year   (other_year),
		.busy         (busy),
		.done         (done),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year),
		.day_count    (day_count),
		.weekday      (weekday),
		.error        (error),
		.step_req     (step_req),
		.step_rsp     (step_rsp)
	);

	// Shared stepper: advance or back off the current date by one day.
	gdsu_step u_step (
		.req (step_req),
		.rsp (step_rsp)
	);

endmodule

[hw/rtl/gdsu_chk.sv]
// Port-level checker for the Gregorian date step unit, bound to the top level.
module gdsu_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [gdsu_pkg::DAY_W-1:0]    result_day,
	input logic [gdsu_pkg::MONTH_W-1:0]  result_month,
	input logic [gdsu_pkg::YEAR_W-1:0]   result_year,
	input logic [gdsu_pkg::DC_W-1:0]     day_count,
	input logic [gdsu_pkg::WD_W-1:0]     weekday,
	input logic                          error
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result shown without a finished item");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && error |-> (result_day == '0) && (result_month == '0)
			&& (result_year == '0) && (day_count == '0) && (weekday == '0))
		else $error("error result carries nonzero fields");

	a_date_sane: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result_month != '0) |-> (result_month <= 4'd12) && (result_day != '0)
			&& (result_year <= gdsu_pkg::MAX_YEAR) && !error)
		else $error("result date out of range");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (weekday <= 3'd6) && (day_count <= 22'd3652424))
		else $error("weekday or day count out of range");

endmodule

bind gregorian_date_step_unit gdsu_chk u_gdsu_chk (.*);
